/* sv/bcc3_pkg.sv */
// ----------------------------------------------------------------------------
// bcc3_pkg
// Shared constants for the 3D barycentric coordinate core.
// ----------------------------------------------------------------------------
package bcc3_pkg;

    // weights leave the core as signed 32-bit words
    localparam int WEIGHT_W = 32;

    // quotient bits resolved by the divider; the top three bits only flag overflow
    localparam int QUOT_BITS = 34;

    // twelve coordinates per input beat
    localparam int N_COORDS = 12;

endpackage

/* sv/barycentric_coords_3d_core.sv */
// ----------------------------------------------------------------------------
// barycentric_coords_3d_core
// Pipelined barycentric weights of a point against a 3D triangle.
// ----------------------------------------------------------------------------
// One beat enters per clock while the output side keeps tready high. The
// pipeline is mostly the restoring divider, which resolves one quotient
// bit per stage over 34 stages for u and w side by side, after seven
// stages of differences, cross products, split dot products and dividend
// set-up, and before a saturation stage and the output register. Each
// stage holds its beat until the next stage frees, so bubbles close up
// while the output is stalled. u = dot((c-b)x(p-b),N)/|N|^2 and
// w = dot((p-b)x(a-b),N)/|N|^2, rounded to nearest with ties away from zero,
// saturated to 32 bits; v = 1 - u - w, saturated. The coordinate scale
// cancels, so the fraction position of the inputs does not matter. A
// zero-area triangle gives the degenerate flag and zero weights.
module barycentric_coords_3d_core #(
    parameter int COORD_WIDTH      = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // fields from bit 0 up: vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x,
    // vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, point_x,
    // point_y, point_z; zero padded to whole bytes
    input  logic [((bcc3_pkg::N_COORDS*COORD_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // fields from bit 0 up: weight_u, weight_v, weight_w
    output logic [3*bcc3_pkg::WEIGHT_W-1:0]        o_m_axis_tdata,
    // fields from bit 0 up: degenerate
    output logic                                   o_m_axis_tuser
);
    import bcc3_pkg::*;

    localparam int DW   = COORD_WIDTH + 1;   // vertex difference
    localparam int MW   = 2 * DW;            // difference product
    localparam int XW   = 2 * DW + 1;        // cross product component
    localparam int SL   = XW / 2;            // low split of second factor
    localparam int SH   = XW - SL;           // high split, signed
    localparam int HPW  = XW + SH;           // high partial product
    localparam int LPW  = XW + SL + 1;       // low partial product
    localparam int PW   = 2 * XW + 2;        // dot product sum
    localparam int DVW  = PW + WEIGHT_FRAC_BITS + 1;
    localparam int RW   = PW + QUOT_BITS;    // divider working width
    localparam int NS   = 7 + QUOT_BITS + 2; // stage count
    localparam int DIV0 = 8;                 // first divider stage
    localparam int SATS = DIV0 + QUOT_BITS;  // saturation stage

    // stage valid bits and per-stage load enables
    logic [NS:1]   r_v;
    logic [NS+1:1] en;

    always_comb begin
        en[NS+1] = i_m_axis_tready;
        for (int k = NS; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_s_axis_tready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_s_axis_tvalid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1: edge vectors from b
    logic [COORD_WIDTH-1:0]  crd [N_COORDS];
    logic signed [DW-1:0]    r_bc [3];
    logic signed [DW-1:0]    r_ba [3];
    logic signed [DW-1:0]    r_bp [3];

    always_comb begin
        for (int i = 0; i < N_COORDS; i++) begin
            crd[i] = i_s_axis_tdata[i*COORD_WIDTH +: COORD_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int i = 0; i < 3; i++) begin
                r_bc[i] <= {crd[6+i][COORD_WIDTH-1], crd[6+i]}
                         - {crd[3+i][COORD_WIDTH-1], crd[3+i]};
                r_ba[i] <= {crd[i][COORD_WIDTH-1], crd[i]}
                         - {crd[3+i][COORD_WIDTH-1], crd[3+i]};
                r_bp[i] <= {crd[9+i][COORD_WIDTH-1], crd[9+i]}
                         - {crd[3+i][COORD_WIDTH-1], crd[3+i]};
            end
        end
    end

    // stages 2 and 3: cross products N = bc x ba, cu = bc x bp, cw = bp x ba
    logic signed [MW-1:0] r_pn0 [3], r_pn1 [3];
    logic signed [MW-1:0] r_pu0 [3], r_pu1 [3];
    logic signed [MW-1:0] r_pw0 [3], r_pw1 [3];
    logic signed [XW-1:0] r_n [3], r_cu [3], r_cw [3];

    for (genvar i = 0; i < 3; i++) begin : g_cross
        localparam int I1 = (i + 1) % 3;
        localparam int I2 = (i + 2) % 3;

        always_ff @(posedge i_clk) begin
            if (en[2]) begin
                r_pn0[i] <= r_bc[I1] * r_ba[I2];
                r_pn1[i] <= r_bc[I2] * r_ba[I1];
                r_pu0[i] <= r_bc[I1] * r_bp[I2];
                r_pu1[i] <= r_bc[I2] * r_bp[I1];
                r_pw0[i] <= r_bp[I1] * r_ba[I2];
                r_pw1[i] <= r_bp[I2] * r_ba[I1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[3]) begin
                r_n[i]  <= {r_pn0[i][MW-1], r_pn0[i]} - {r_pn1[i][MW-1], r_pn1[i]};
                r_cu[i] <= {r_pu0[i][MW-1], r_pu0[i]} - {r_pu1[i][MW-1], r_pu1[i]};
                r_cw[i] <= {r_pw0[i][MW-1], r_pw0[i]} - {r_pw1[i][MW-1], r_pw1[i]};
            end
        end
    end

    // stage 4: dot product terms as split partial products against N
    logic signed [SH-1:0]  nh [3];
    logic signed [SL:0]    nl [3];
    logic signed [HPW-1:0] r_hd [3], r_hu [3], r_hw [3];
    logic signed [LPW-1:0] r_ld [3], r_lu [3], r_lw [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nh[i] = r_n[i][XW-1:SL];
            nl[i] = {1'b0, r_n[i][SL-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            for (int i = 0; i < 3; i++) begin
                r_hd[i] <= r_n[i]  * nh[i];
                r_ld[i] <= r_n[i]  * nl[i];
                r_hu[i] <= r_cu[i] * nh[i];
                r_lu[i] <= r_cu[i] * nl[i];
                r_hw[i] <= r_cw[i] * nh[i];
                r_lw[i] <= r_cw[i] * nl[i];
            end
        end
    end

    // stage 5: gather partials into |N|^2 and the two numerators
    logic signed [PW-1:0] r_den5, r_nu5, r_nw5;
    logic signed [PW-1:0] sd, su, sw;

    always_comb begin
        sd = '0;
        su = '0;
        sw = '0;
        for (int i = 0; i < 3; i++) begin
            sd = sd + (PW'(r_hd[i]) <<< SL) + PW'(r_ld[i]);
            su = su + (PW'(r_hu[i]) <<< SL) + PW'(r_lu[i]);
            sw = sw + (PW'(r_hw[i]) <<< SL) + PW'(r_lw[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_den5 <= sd;
            r_nu5  <= su;
            r_nw5  <= sw;
        end
    end

    // stage 6: sign and magnitude of numerators, zero-area test
    logic [PW-1:0] r_den6, r_mu6, r_mw6;
    logic          r_su6, r_sw6, r_dg6;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_den6 <= r_den5;
            r_dg6  <= (r_den5 == '0);
            r_su6  <= r_nu5[PW-1];
            r_sw6  <= r_nw5[PW-1];
            r_mu6  <= r_nu5[PW-1] ? PW'(-r_nu5) : r_nu5;
            r_mw6  <= r_nw5[PW-1] ? PW'(-r_nw5) : r_nw5;
        end
    end

    // stage 7 and divider: rounded dividend, one quotient bit per stage
    logic [RW-1:0]        r_ru [QUOT_BITS+1], r_rw [QUOT_BITS+1];
    logic [QUOT_BITS-1:0] r_qu [QUOT_BITS+1], r_qw [QUOT_BITS+1];
    logic [PW-1:0]        r_dd [QUOT_BITS+1];
    logic                 r_su [QUOT_BITS+1], r_sw [QUOT_BITS+1];
    logic                 r_dg [QUOT_BITS+1];

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_ru[0] <= RW'((DVW'(r_mu6) << WEIGHT_FRAC_BITS) + DVW'(r_den6 >> 1));
            r_rw[0] <= RW'((DVW'(r_mw6) << WEIGHT_FRAC_BITS) + DVW'(r_den6 >> 1));
            r_qu[0] <= '0;
            r_qw[0] <= '0;
            r_dd[0] <= r_den6;
            r_su[0] <= r_su6;
            r_sw[0] <= r_sw6;
            r_dg[0] <= r_dg6;
        end
    end

    for (genvar j = 0; j < QUOT_BITS; j++) begin : g_div
        localparam int QB = QUOT_BITS - 1 - j;
        logic [RW-1:0] dsh;

        assign dsh = RW'(r_dd[j]) << QB;

        always_ff @(posedge i_clk) begin
            if (en[DIV0+j]) begin
                r_dd[j+1] <= r_dd[j];
                r_su[j+1] <= r_su[j];
                r_sw[j+1] <= r_sw[j];
                r_dg[j+1] <= r_dg[j];
                if (r_ru[j] >= dsh) begin
                    r_ru[j+1] <= r_ru[j] - dsh;
                    r_qu[j+1] <= r_qu[j] | (QUOT_BITS'(1) << QB);
                end else begin
                    r_ru[j+1] <= r_ru[j];
                    r_qu[j+1] <= r_qu[j];
                end
                if (r_rw[j] >= dsh) begin
                    r_rw[j+1] <= r_rw[j] - dsh;
                    r_qw[j+1] <= r_qw[j] | (QUOT_BITS'(1) << QB);
                end else begin
                    r_rw[j+1] <= r_rw[j];
                    r_qw[j+1] <= r_qw[j];
                end
            end
        end
    end

    // saturate quotient with sign applied
    function automatic logic signed [WEIGHT_W-1:0] sat_q(
        input logic [QUOT_BITS-1:0] q,
        input logic                 neg
    );
        logic big;
        big = (q[QUOT_BITS-1:WEIGHT_W-1] != '0);
        if (big) begin
            sat_q = neg ? {1'b1, {(WEIGHT_W-1){1'b0}}} : {1'b0, {(WEIGHT_W-1){1'b1}}};
        end else begin
            sat_q = neg ? -q[WEIGHT_W-1:0] : q[WEIGHT_W-1:0];
        end
    endfunction

    logic signed [WEIGHT_W-1:0] r_u, r_w;
    logic                       r_dgs;

    always_ff @(posedge i_clk) begin
        if (en[SATS]) begin
            r_dgs <= r_dg[QUOT_BITS];
            if (r_dg[QUOT_BITS]) begin
                r_u <= '0;
                r_w <= '0;
            end else begin
                r_u <= sat_q(r_qu[QUOT_BITS], r_su[QUOT_BITS]);
                r_w <= sat_q(r_qw[QUOT_BITS], r_sw[QUOT_BITS]);
            end
        end
    end

    // output register: v = 1 - u - w, saturated
    localparam int VW = WEIGHT_W + 2;
    logic signed [VW-1:0]       vs;
    logic signed [WEIGHT_W-1:0] vsat;
    logic signed [WEIGHT_W-1:0] r_ou, r_ov, r_ow;
    logic                       r_odg;

    always_comb begin
        vs = (VW'(1) << WEIGHT_FRAC_BITS) - VW'(r_u) - VW'(r_w);
        if (vs > $signed(VW'({1'b0, {(WEIGHT_W-1){1'b1}}}))) begin
            vsat = {1'b0, {(WEIGHT_W-1){1'b1}}};
        end else if (vs < -(VW'(1) <<< (WEIGHT_W-1))) begin
            vsat = {1'b1, {(WEIGHT_W-1){1'b0}}};
        end else begin
            vsat = vs[WEIGHT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NS]) begin
            r_ou  <= r_u;
            r_ow  <= r_w;
            r_ov  <= r_dgs ? '0 : vsat;
            r_odg <= r_dgs;
        end
    end

    assign o_m_axis_tvalid = r_v[NS];
    assign o_m_axis_tdata  = {r_ow, r_ov, r_ou};
    assign o_m_axis_tuser  = r_odg;

endmodule

/* sv/bcc3_checker.sv */
// ----------------------------------------------------------------------------
// bcc3_checker
// Port-level assertions for the barycentric coordinate core.
// ----------------------------------------------------------------------------
module bcc3_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [95:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);
    // a stalled output beat stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output beat dropped while stalled");

    // degenerate triangle carries zero weights
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("degenerate beat with nonzero weights");

    // an empty output stage never holds off the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input blocked with empty output");

    // nothing comes out straight after reset
    a_rst: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_m_axis_tvalid)
        else $error("output valid after reset");
endmodule

bind barycentric_coords_3d_core bcc3_checker u_bcc3_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
